// ===== hw/rtl/cleb_pkg.sv =====
// ----------------------------------------------------------------------------
// Line edit buffer package
// Shared sizes, keystroke codes, sequencer states and memory request type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cleb_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHAR_W   = 8;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [CHAR_W-1:0] KEY_LEFT  = 8'h3C;
  localparam logic [CHAR_W-1:0] KEY_RIGHT = 8'h3E;
  localparam logic [CHAR_W-1:0] KEY_BACK  = 8'h2D;

  localparam logic KIND_KEY   = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE_L,
    ST_MOVE_R,
    ST_DRAIN_L,
    ST_DRAIN_R
  } st_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] wdata;
  } mem_req_t;

endpackage

// ===== hw/rtl/cleb_if.sv =====
// ----------------------------------------------------------------------------
// Line edit buffer channels
// Valid/ready channels for keystroke items and for result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cleb_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [cleb_pkg::CHAR_W-1:0] key_char;

  modport source (output valid, output kind, output key_char, input ready);
  modport sink   (input valid, input kind, input key_char, output ready);
endinterface

interface cleb_out_if;
  logic                       valid;
  logic                       ready;
  logic [cleb_pkg::CHAR_W-1:0] out_char;
  logic                       out_valid;
  logic                       line_done;
  logic                       overflow;

  modport source (output valid, output out_char, output out_valid, output line_done,
                  output overflow, input ready);
  modport sink   (input valid, input out_char, input out_valid, input line_done,
                  input overflow, output ready);
endinterface

// ===== hw/rtl/cleb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// Reads each cycle, writes if enabled, at a shared address; registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cleb_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/cleb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Line edit buffer sequencer
// Keeps the stack counts and drain position, issues stack memory accesses
// and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cleb_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  cleb_in_if.sink                       in_chan,
  cleb_out_if.source                    out_chan,
  output cleb_pkg::mem_req_t            left_req,
  output cleb_pkg::mem_req_t            right_req,
  input  logic [cleb_pkg::CHAR_W-1:0]   left_rdata,
  input  logic [cleb_pkg::CHAR_W-1:0]   right_rdata
);

  cleb_pkg::st_t st_r, st_nxt;

  logic [cleb_pkg::CNT_W-1:0]  lc_r, lc_nxt;
  logic [cleb_pkg::CNT_W-1:0]  rc_r, rc_nxt;
  logic [cleb_pkg::CNT_W-1:0]  pos_r, pos_nxt;
  logic [cleb_pkg::ADDR_W-1:0] wr_addr_r, wr_addr_nxt;

  logic                        ov_r, ov_nxt;
  logic [cleb_pkg::CHAR_W-1:0] oc_r, oc_nxt;
  logic                        ocv_r, ocv_nxt;
  logic                        od_r, od_nxt;
  logic                        oovf_r, oovf_nxt;

  logic                       acc;
  logic                       clr;
  logic [cleb_pkg::CNT_W-1:0] lc_e, rc_e;
  logic [cleb_pkg::CNT_W-1:0] total, total_e;
  logic [cleb_pkg::CNT_W-1:0] pos_inc;
  logic [cleb_pkg::CNT_W-1:0] right_pos;
  logic                       is_key;
  logic                       move_l_ok, move_r_ok;
  logic                       drain_any, drain_left;

  assign acc    = in_chan.valid && in_chan.ready;
  assign is_key = (in_chan.kind == cleb_pkg::KIND_KEY);

  // A keystroke arriving part way through a drain sees an empty line.
  assign clr     = (pos_r != '0);
  assign lc_e    = clr ? '0 : lc_r;
  assign rc_e    = clr ? '0 : rc_r;
  assign total   = lc_r + rc_r;
  assign total_e = lc_e + rc_e;
  assign pos_inc = pos_r + cleb_pkg::CNT_W'(1);
  // Line positions beyond the left stack count down from the right stack top.
  assign right_pos = total - pos_r - cleb_pkg::CNT_W'(1);

  assign move_l_ok = is_key && (in_chan.key_char == cleb_pkg::KEY_LEFT)
                     && (lc_e != '0) && (rc_e < cleb_pkg::CAP_CNT);
  assign move_r_ok = is_key && (in_chan.key_char == cleb_pkg::KEY_RIGHT)
                     && (rc_e != '0) && (lc_e < cleb_pkg::CAP_CNT);
  assign drain_any  = !is_key && (total != '0);
  assign drain_left = (pos_r < lc_r);

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      cleb_pkg::ST_IDLE: begin
        if (acc) begin
          if (move_l_ok) begin
            st_nxt = cleb_pkg::ST_MOVE_L;
          end else if (move_r_ok) begin
            st_nxt = cleb_pkg::ST_MOVE_R;
          end else if (drain_any) begin
            st_nxt = drain_left ? cleb_pkg::ST_DRAIN_L : cleb_pkg::ST_DRAIN_R;
          end
        end
      end
      cleb_pkg::ST_MOVE_L, cleb_pkg::ST_MOVE_R,
      cleb_pkg::ST_DRAIN_L, cleb_pkg::ST_DRAIN_R: begin
        st_nxt = cleb_pkg::ST_IDLE;
      end
      default: begin
        st_nxt = cleb_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs: take a new item only when the result register is free.
  always_comb begin
    in_chan.ready = (st_r == cleb_pkg::ST_IDLE) && (!ov_r || out_chan.ready);
  end

  // Datapath and memory requests
  always_comb begin
    lc_nxt      = lc_r;
    rc_nxt      = rc_r;
    pos_nxt     = pos_r;
    wr_addr_nxt = wr_addr_r;
    ov_nxt      = ov_r;
    oc_nxt      = oc_r;
    ocv_nxt     = ocv_r;
    od_nxt      = od_r;
    oovf_nxt    = oovf_r;
    left_req    = '0;
    right_req   = '0;

    if (out_chan.valid && out_chan.ready) begin
      ov_nxt = 1'b0;
    end

    case (st_r)
      cleb_pkg::ST_IDLE: begin
        if (acc) begin
          oc_nxt   = '0;
          ocv_nxt  = 1'b0;
          od_nxt   = 1'b0;
          oovf_nxt = 1'b0;
          if (is_key) begin
            lc_nxt  = lc_e;
            rc_nxt  = rc_e;
            pos_nxt = '0;
            if (move_l_ok) begin
              left_req.addr = cleb_pkg::ADDR_W'(lc_e - cleb_pkg::CNT_W'(1));
              wr_addr_nxt   = rc_e[cleb_pkg::ADDR_W-1:0];
              lc_nxt        = lc_e - cleb_pkg::CNT_W'(1);
              rc_nxt        = rc_e + cleb_pkg::CNT_W'(1);
            end else if (move_r_ok) begin
              right_req.addr = cleb_pkg::ADDR_W'(rc_e - cleb_pkg::CNT_W'(1));
              wr_addr_nxt    = lc_e[cleb_pkg::ADDR_W-1:0];
              rc_nxt         = rc_e - cleb_pkg::CNT_W'(1);
              lc_nxt         = lc_e + cleb_pkg::CNT_W'(1);
            end else begin
              ov_nxt = 1'b1;
              if (in_chan.key_char == cleb_pkg::KEY_BACK) begin
                if (lc_e != '0) begin
                  lc_nxt = lc_e - cleb_pkg::CNT_W'(1);
                end
              end else if (in_chan.key_char != cleb_pkg::KEY_LEFT &&
                           in_chan.key_char != cleb_pkg::KEY_RIGHT) begin
                if (total_e >= cleb_pkg::CAP_CNT) begin
                  oovf_nxt = 1'b1;
                end else begin
                  left_req.we    = 1'b1;
                  left_req.addr  = lc_e[cleb_pkg::ADDR_W-1:0];
                  left_req.wdata = in_chan.key_char;
                  lc_nxt         = lc_e + cleb_pkg::CNT_W'(1);
                end
              end
            end
          end else if (total == '0) begin
            ov_nxt = 1'b1;
            od_nxt = 1'b1;
          end else begin
            // The character comes out of the memory next cycle.
            ocv_nxt = 1'b1;
            if (drain_left) begin
              left_req.addr = pos_r[cleb_pkg::ADDR_W-1:0];
            end else begin
              right_req.addr = right_pos[cleb_pkg::ADDR_W-1:0];
            end
            if (pos_inc >= total) begin
              od_nxt  = 1'b1;
              lc_nxt  = '0;
              rc_nxt  = '0;
              pos_nxt = '0;
            end else begin
              pos_nxt = pos_inc;
            end
          end
        end
      end
      cleb_pkg::ST_MOVE_L: begin
        right_req.we    = 1'b1;
        right_req.addr  = wr_addr_r;
        right_req.wdata = left_rdata;
        ov_nxt          = 1'b1;
      end
      cleb_pkg::ST_MOVE_R: begin
        left_req.we    = 1'b1;
        left_req.addr  = wr_addr_r;
        left_req.wdata = right_rdata;
        ov_nxt         = 1'b1;
      end
      cleb_pkg::ST_DRAIN_L: begin
        oc_nxt = left_rdata;
        ov_nxt = 1'b1;
      end
      cleb_pkg::ST_DRAIN_R: begin
        oc_nxt = right_rdata;
        ov_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= cleb_pkg::ST_IDLE;
      lc_r  <= '0;
      rc_r  <= '0;
      pos_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      lc_r  <= lc_nxt;
      rc_r  <= rc_nxt;
      pos_r <= pos_nxt;
      ov_r  <= ov_nxt;
    end
    wr_addr_r <= wr_addr_nxt;
    oc_r      <= oc_nxt;
    ocv_r     <= ocv_nxt;
    od_r      <= od_nxt;
    oovf_r    <= oovf_nxt;
  end

  assign out_chan.valid     = ov_r;
  assign out_chan.out_char  = oc_r;
  assign out_chan.out_valid = ocv_r;
  assign out_chan.line_done = od_r;
  assign out_chan.overflow  = oovf_r;

  // The two stacks together never hold more than the line capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (lc_r + rc_r) <= cleb_pkg::CAP_CNT)
    else $error("stack counts exceed capacity");

  // A drain in progress always points inside the line.
  a_pos_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != '0) |-> (pos_r < lc_r + rc_r))
    else $error("drain position beyond end of line");

  // The memory access cycle always ends with a result transfer loaded.
  a_second_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != cleb_pkg::ST_IDLE) |=> (st_r == cleb_pkg::ST_IDLE) && ov_r)
    else $error("memory cycle did not produce a result");

  // No memory write lands while a read for the same item is outstanding.
  a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == cleb_pkg::ST_DRAIN_L || st_r == cleb_pkg::ST_DRAIN_R)
    |-> !left_req.we && !right_req.we)
    else $error("stack write during a drain read");

endmodule

// ===== hw/rtl/cursor_line_edit_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// Cursor line edit buffer
// Line editor with a cursor, held as two stacks in two stack memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Each item gives exactly one result. Inserts, backspaces, cursor moves at
// the edge of the line and drains of an empty line are done in the idle state;
// cursor moves and character drains also pass through a move or drain state,
// as they wait for the registered stack memory read before writing the other
// stack or loading the result. A new item is taken while the previous result
// is still pending only if that result is transferred in the same cycle. The
// stack memories need no clearing after reset, so the block is ready at once.

module cursor_line_edit_buffer_unit (
  input  logic       clk,
  input  logic       rst_n,
  cleb_in_if.sink    in_chan,
  cleb_out_if.source out_chan
);

  cleb_pkg::mem_req_t          left_req;
  cleb_pkg::mem_req_t          right_req;
  logic [cleb_pkg::CHAR_W-1:0] left_rdata;
  logic [cleb_pkg::CHAR_W-1:0] right_rdata;

  cleb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .left_req   (left_req),
    .right_req  (right_req),
    .left_rdata (left_rdata),
    .right_rdata(right_rdata)
  );

  cleb_ram #(
    .DATA_W(cleb_pkg::CHAR_W),
    .DEPTH (cleb_pkg::CAPACITY)
  ) u_left_ram (
    .clk  (clk),
    .we   (left_req.we),
    .addr (left_req.addr),
    .wdata(left_req.wdata),
    .rdata(left_rdata)
  );

  cleb_ram #(
    .DATA_W(cleb_pkg::CHAR_W),
    .DEPTH (cleb_pkg::CAPACITY)
  ) u_right_ram (
    .clk  (clk),
    .we   (right_req.we),
    .addr (right_req.addr),
    .wdata(right_req.wdata),
    .rdata(right_rdata)
  );

endmodule
